// ===== rtl/tnrs_pkg.sv =====
// Package for the top-N row selector: sizes, defaults and register indexes.
// Used by every module in rtl/; depends on nothing.
package tnrs_pkg;
  localparam int CAPACITY_DEF = 16;
  localparam int MAX_KEYS_DEF = 3;
  localparam int KEY_BITS_DEF = 32;
  localparam int KEY_FIELDS = 3;
  localparam int FIELD_BITS = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 5;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ASCENDING = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_COUNT = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic insert;   // place the accepted row
    logic clear;    // empty the set after output
    logic emit;     // advance the read pointer past the presented slot
  } tnrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic emit_done; // the read pointer sits on the final kept row
    logic empty;     // nothing to emit
  } tnrs_stat_t;
endpackage

// ===== rtl/tnrs_datapath.sv =====
// Datapath of the top-N row selector: insertion array of kept rows with
// per-slot compare and shift, and the output register. Depends on tnrs_pkg.
module tnrs_datapath
  import tnrs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tnrs_cmd_t              cmd,
  output tnrs_stat_t             stat,
  input  logic [4:0]             keep_count,
  input  logic                   ascending,
  input  logic [1:0]             key_count,
  input  logic [FIELD_BITS-1:0]  row_id,
  input  logic [FIELD_BITS-1:0]  key_first,
  input  logic [FIELD_BITS-1:0]  key_second,
  input  logic [FIELD_BITS-1:0]  key_third,
  input  logic                   out_load,
  output logic [FIELD_BITS-1:0]  out_row_id,
  output logic [FIELD_BITS-1:0]  out_key_first,
  output logic [FIELD_BITS-1:0]  out_key_second,
  output logic [FIELD_BITS-1:0]  out_key_third,
  output logic [3:0]             out_rank,
  output logic                   out_last
);
  localparam int TB = $clog2(CAPACITY + 1);
  localparam int PB = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [FIELD_BITS-1:0] ids [CAPACITY];
  logic [KEY_BITS-1:0]   keys [CAPACITY][MAX_KEYS];
  logic [TB-1:0]         total;
  logic [TB-1:0]         rd_ptr;
  logic [TB-1:0]         limit;
  logic [TB-1:0]         cnt;
  logic [3:0]            nkeys;
  logic [KEY_BITS-1:0]   cand [MAX_KEYS];
  logic [CAPACITY-1:0]   better;
  logic                  worse_last;
  logic                  do_ins;
  logic [TB-1:0]         base;

  // effective limit and key count
  always_comb begin
    if (keep_count == 5'd0) limit = TB'(1);
    else if (32'(keep_count) > CAPACITY) limit = TB'(CAPACITY);
    else limit = TB'(keep_count);
    if (key_count == 2'd0) nkeys = 4'd1;
    else if (32'(key_count) > MAX_KEYS) nkeys = 4'(MAX_KEYS);
    else nkeys = 4'(key_count);
    cnt = (total < limit) ? total : limit;
  end

  // candidate keys, masked to the stored width
  always_comb begin
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (i == 0) cand[i] = KEY_BITS'(key_first);
      else if (i == 1) cand[i] = KEY_BITS'(key_second);
      else if (i == 2) cand[i] = KEY_BITS'(key_third);
      else cand[i] = '0;
    end
  end

  // per-slot lexicographic compare
  always_comb begin
    logic done_b;
    logic done_w;
    logic [PB-1:0] wi;
    wi = PB'(total - TB'(1));
    worse_last = 1'b0;
    done_w = 1'b0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (!done_w && 4'(i) < nkeys && cand[i] != keys[wi][i]) begin
        done_w = 1'b1;
        worse_last = ascending ? (cand[i] > keys[wi][i]) : (cand[i] < keys[wi][i]);
      end
    end
    for (int s = 0; s < CAPACITY; s++) begin
      better[s] = 1'b0;
      done_b = 1'b0;
      for (int i = 0; i < MAX_KEYS; i++) begin
        if (!done_b && 4'(i) < nkeys && cand[i] != keys[s][i]) begin
          done_b = 1'b1;
          better[s] = ascending ? (cand[i] < keys[s][i]) : (cand[i] > keys[s][i]);
        end
      end
    end
  end

  // insert when room, or replace the worst row when not worse
  always_comb begin
    do_ins = 1'b0;
    base = total;
    if (total < limit) do_ins = 1'b1;
    else if (total != '0 && !worse_last) begin
      do_ins = 1'b1;
      base = total - TB'(1);
    end
  end

  // shift array: slots at or past the insertion point move down one
  always_ff @(posedge clk) begin
    if (cmd.insert && do_ins) begin
      for (int s = 0; s < CAPACITY; s++) begin
        logic at_or_after;
        logic prev_after;
        at_or_after = 1'b0;
        prev_after = 1'b0;
        for (int j = 0; j <= s; j++) begin
          if (TB'(j) < base && better[j]) at_or_after = 1'b1;
          if (j < s && TB'(j) < base && better[j]) prev_after = 1'b1;
        end
        if (TB'(s) <= base) begin
          if (prev_after && s > 0) begin
            ids[s] <= ids[s-1];
            keys[s] <= keys[s-1];
          end else if (at_or_after || TB'(s) == base) begin
            ids[s] <= row_id;
            for (int i = 0; i < MAX_KEYS; i++) keys[s][i] <= cand[i];
          end
        end
      end
    end
  end

  // fill count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      rd_ptr <= '0;
    end else begin
      if (cmd.insert && do_ins) total <= base + TB'(1);
      if (cmd.emit) rd_ptr <= rd_ptr + TB'(1);
      if (cmd.clear) begin
        total <= '0;
        rd_ptr <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_id <= ids[PB'(rd_ptr)];
      out_key_first <= FIELD_BITS'(keys[PB'(rd_ptr)][0]);
      out_key_second <= (MAX_KEYS > 1) ? FIELD_BITS'(keys[PB'(rd_ptr)][(MAX_KEYS > 1) ? 1 : 0])
                                       : '0;
      out_key_third <= (MAX_KEYS > 2) ? FIELD_BITS'(keys[PB'(rd_ptr)][(MAX_KEYS > 2) ? 2 : 0])
                                      : '0;
      out_rank <= 4'(rd_ptr);
      out_last <= (rd_ptr + TB'(1) == cnt);
    end
  end

  assign stat.empty = (cnt == '0);
  assign stat.emit_done = (rd_ptr + TB'(1) == cnt);
endmodule

// ===== rtl/tnrs_ctrl.sv =====
// Controller of the top-N row selector: accepts rows, runs the output
// sweep and drives the output valid. Depends on tnrs_pkg.
module tnrs_ctrl
  import tnrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       last_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_load,
  output tnrs_cmd_t  cmd,
  input  tnrs_stat_t stat
);
  typedef enum logic [1:0] {S_IN, S_CHECK, S_EMIT} state_t;
  state_t state;
  logic   in_acc;
  logic   slot_free;

  assign in_stall = (state != S_IN);
  assign in_acc = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign out_load = (state == S_EMIT) && slot_free;

  always_comb begin
    cmd.insert = in_acc;
    cmd.emit = out_load;
    cmd.clear = out_load && stat.emit_done;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) out_valid <= out_load;
      unique case (state)
        S_IN: if (in_acc && last_row) state <= S_CHECK;
        S_CHECK: begin
          if (stat.empty) state <= S_IN;
          else state <= S_EMIT;
        end
        S_EMIT: if (out_load && stat.emit_done) state <= S_IN;
        default: state <= S_IN;
      endcase
    end
  end
endmodule

// ===== rtl/top_n_row_selector.sv =====
// Top-N row selector: keeps the best rows of a set and emits them sorted.
// An accepted row is written into the array at the next clock; a last row
// goes via S_CHECK to S_EMIT, then one kept row a cycle unless output stalls.
// Throughput: one row a cycle; the output sweep of N rows blocks input.
// Reset (rst, synchronous): empty set, registers at 16 / ascending / 1 key.
module top_n_row_selector
  import tnrs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FIELD_BITS-1:0]    row_id,
  input  logic [FIELD_BITS-1:0]    key_first,
  input  logic [FIELD_BITS-1:0]    key_second,
  input  logic [FIELD_BITS-1:0]    key_third,
  input  logic                     last_row,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FIELD_BITS-1:0]    out_row_id,
  output logic [FIELD_BITS-1:0]    out_key_first,
  output logic [FIELD_BITS-1:0]    out_key_second,
  output logic [FIELD_BITS-1:0]    out_key_third,
  output logic [3:0]               out_rank,
  output logic                     out_last
);
  logic [4:0] keep_count;
  logic       ascending;
  logic [1:0] key_count;
  logic       out_load;
  tnrs_cmd_t  cmd;
  tnrs_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= 5'd16;
      ascending <= 1'b1;
      key_count <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEEP_COUNT: keep_count <= cfg_data;
        REG_ASCENDING: ascending <= cfg_data[0];
        REG_KEY_COUNT: key_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  tnrs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .last_row, .out_valid, .out_stall,
    .out_load, .cmd, .stat
  );

  tnrs_datapath #(.CAPACITY(CAPACITY), .MAX_KEYS(MAX_KEYS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .keep_count, .ascending, .key_count,
    .row_id, .key_first, .key_second, .key_third, .out_load,
    .out_row_id, .out_key_first, .out_key_second, .out_key_third,
    .out_rank, .out_last
  );
endmodule

// ===== sim/tnrs_checker.sv =====
// Checker for the top-N row selector: watches both channels, keeps its own
// sorted row store and compares every emitted beat. Depends on tnrs_pkg.
`timescale 1ns / 1ps
module tnrs_checker
  import tnrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [FIELD_BITS-1:0]    row_id,
  input  logic [FIELD_BITS-1:0]    key_first,
  input  logic [FIELD_BITS-1:0]    key_second,
  input  logic [FIELD_BITS-1:0]    key_third,
  input  logic                     last_row,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [FIELD_BITS-1:0]    out_row_id,
  input  logic [FIELD_BITS-1:0]    out_key_first,
  input  logic [FIELD_BITS-1:0]    out_key_second,
  input  logic [FIELD_BITS-1:0]    out_key_third,
  input  logic [3:0]               out_rank,
  input  logic                     out_last,
  output int                       errors,
  output int                       pending,
  output int                       emitted
);
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [3:0]  rank;
    logic        fin;
  } sel_row_t;

  sel_row_t    kept_rows [CAPACITY_DEF];
  int          kept_n;
  logic [4:0]  keep_cfg;
  logic        asc_cfg;
  logic [1:0]  keys_cfg;
  sel_row_t    expected_rows [$];

  assign pending = expected_rows.size();

  // compare candidate against a stored row: -1 before, 0 equal, 1 after
  function automatic int rank_order(sel_row_t c, sel_row_t s);
    logic [31:0] a [3];
    logic [31:0] b [3];
    int nk;
    a = '{c.k0, c.k1, c.k2};
    b = '{s.k0, s.k1, s.k2};
    nk = (keys_cfg == 0) ? 1 : int'(keys_cfg);
    for (int i = 0; i < nk; i++) begin
      if (a[i] != b[i]) begin
        if (asc_cfg) return (a[i] < b[i]) ? -1 : 1;
        else return (a[i] > b[i]) ? -1 : 1;
      end
    end
    return 0;
  endfunction

  task automatic place_row(sel_row_t c);
    int p;
    int limit;
    limit = (keep_cfg == 0) ? 1 : ((keep_cfg > CAPACITY_DEF) ? CAPACITY_DEF : int'(keep_cfg));
    if (kept_n >= limit) begin
      if (kept_n == 0 || rank_order(c, kept_rows[kept_n-1]) > 0) return;
      kept_n--;
    end
    p = 0;
    while (p < kept_n && rank_order(c, kept_rows[p]) >= 0) p++;
    for (int j = kept_n; j > p; j--) kept_rows[j] = kept_rows[j-1];
    kept_rows[p] = c;
    kept_n++;
  endtask

  task automatic close_set();
    int limit;
    int cnt;
    sel_row_t r;
    limit = (keep_cfg == 0) ? 1 : ((keep_cfg > CAPACITY_DEF) ? CAPACITY_DEF : int'(keep_cfg));
    cnt = (kept_n < limit) ? kept_n : limit;
    for (int i = 0; i < cnt; i++) begin
      r = kept_rows[i];
      r.rank = i[3:0];
      r.fin = (i + 1 == cnt);
      expected_rows.insert(expected_rows.size(), r);
    end
    kept_n = 0;
  endtask

  // track config, predict on input beats, compare output beats
  always @(posedge clk) begin
    sel_row_t c;
    sel_row_t e;
    if (rst) begin
      kept_n = 0;
      keep_cfg = 5'd16;
      asc_cfg = 1'b1;
      keys_cfg = 2'd1;
      errors = 0;
      emitted = 0;
      expected_rows.delete();
    end else begin
      if (out_valid && !out_stall) begin
        emitted++;
        if (expected_rows.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat id=%h rank=%0d", $time, out_row_id, out_rank);
        end else begin
          e = expected_rows.pop_front();
          if (e.id !== out_row_id || e.k0 !== out_key_first || e.k1 !== out_key_second ||
              e.k2 !== out_key_third || e.rank !== out_rank || e.fin !== out_last) begin
            errors++;
            $display("%0t: mismatch expected id=%h k=%h/%h/%h rank=%0d last=%b",
                     $time, e.id, e.k0, e.k1, e.k2, e.rank, e.fin);
            $display("%0t:          actual   id=%h k=%h/%h/%h rank=%0d last=%b",
                     $time, out_row_id, out_key_first, out_key_second, out_key_third,
                     out_rank, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        c = '{row_id, key_first, key_second, key_third, 4'd0, 1'b0};
        place_row(c);
        if (last_row) close_set();
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KEEP_COUNT: keep_cfg = cfg_data;
          REG_ASCENDING:  asc_cfg = cfg_data[0];
          REG_KEY_COUNT:  keys_cfg = cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the top-N row selector: makes rows, idles both sides,
// and gives the verdict. Depends on tnrs_pkg, tnrs_checker and the RTL.
`timescale 1ns / 1ps
module tb;
  import tnrs_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FIELD_BITS-1:0] row_id = '0, key_first = '0, key_second = '0, key_third = '0;
  logic last_row = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [FIELD_BITS-1:0] out_row_id, out_key_first, out_key_second, out_key_third;
  logic [3:0] out_rank;
  logic out_last;
  int errors, pending, emitted;
  int idle_cycles = 0;
  int rows_sent = 0;
  int sets_sent = 0;
  bit hold_out = 1'b0;
  bit flood = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  top_n_row_selector u_dut (.*);

  tnrs_checker u_chk (.*);

  // stall the output at random (never in flood mode), or hard while a hold-off is asked
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (flood) w = 0;
        if (w != 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // offer one row and hold it until accepted
  task automatic send_row(logic [31:0] id, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic fin, bit gaps);
    int w;
    w = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11)) : 0;
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1'b1;
    row_id <= id;
    key_first <= a;
    key_second <= b;
    key_third <= c;
    last_row <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    rows_sent++;
    if (fin) sets_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // narrow key values make ties and multi-column decisions common
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 2);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_set(int len, bit gaps);
    for (int i = 0; i < len; i++)
      send_row($urandom(), pick_key(), pick_key(), pick_key(), i == len - 1, gaps);
  endtask

  initial begin
    int len;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: defaults, ties, extremes, single row
    send_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_row(32'h1, 32'h0, 32'h5, 32'h0, 1'b0, 1'b0);
    send_row(32'h2, 32'h7, 32'h0, 32'h0, 1'b1, 1'b0);
    send_row(32'h3, 32'h9, 32'h1, 32'h2, 1'b1, 1'b0);
    drain();
    write_reg(REG_KEEP_COUNT, 5'd2);
    write_reg(REG_ASCENDING, 5'd0);
    write_reg(REG_KEY_COUNT, 5'd3);
    send_row(32'h10, 32'h5, 32'h5, 32'h1, 1'b0, 1'b0);
    send_row(32'h11, 32'h5, 32'h5, 32'h1, 1'b0, 1'b0);
    send_row(32'h12, 32'h5, 32'h5, 32'h2, 1'b0, 1'b0);
    send_row(32'h13, 32'h5, 32'h5, 32'h1, 1'b0, 1'b0);
    send_row(32'h14, 32'h4, 32'hFFFF_FFFF, 32'h9, 1'b1, 1'b0);
    drain();
    write_reg(REG_KEEP_COUNT, 5'd0);
    write_reg(REG_KEY_COUNT, 5'd0);
    send_row(32'h20, 32'h1, 32'h0, 32'h0, 1'b0, 1'b0);
    send_row(32'h21, 32'h1, 32'h9, 32'h0, 1'b1, 1'b0);
    drain();
    write_reg(REG_KEEP_COUNT, 5'd31);
    write_reg(REG_ASCENDING, 5'd1);
    write_reg(REG_KEY_COUNT, 5'd2);
    random_set(18, 1'b0);
    drain();

    // output held off while input floods, so the block must stall its input
    write_reg(REG_KEEP_COUNT, 5'd16);
    hold_out = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_out = 1'b0;
      end
      begin
        random_set(6, 1'b0);
        random_set(6, 1'b0);
      end
    join
    drain();

    // random sets over a range of settings
    while (rows_sent < 270) begin
      write_reg(REG_KEEP_COUNT,
                ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(1, 31)));
      write_reg(REG_ASCENDING, 5'($urandom_range(0, 1)));
      write_reg(REG_KEY_COUNT, 5'($urandom_range(0, 3)));
      flood = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      random_set(len, !flood);
      if ($urandom_range(0, 1)) drain();
      else begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
      end
    end
    flood = 1'b0;
    drain();
    repeat (20) @(negedge clk);

    $display("Covered %0d rows in %0d sets, %0d rows emitted, under varied keep/order/key",
             rows_sent, sets_sent, emitted);
    $display("settings with output hold-off and random stalls on both sides.");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/tnrs_pkg.sv
rtl/tnrs_datapath.sv
rtl/tnrs_ctrl.sv
rtl/top_n_row_selector.sv
sim/tnrs_checker.sv
sim/tb.sv
